// ----- rtl/sbt_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// sbt_pkg
// Shared types and constants of the setpoint band trigger: transaction
// payloads, configuration register set, register map and request codes.
// ---------------------------------------------------------------------------
package sbt_pkg;

    // default number of out-of-band samples before a request fires
    localparam int CHECKS_NEEDED_DEF = 5;

    // configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_CONTROL_ENABLED  = 3'd0,
        REG_DOSER_MODE       = 3'd1,
        REG_RAISE_ENABLE     = 3'd2,
        REG_LOWER_ENABLE     = 3'd3,
        REG_DAY_NIGHT_ENABLE = 3'd4,
        REG_DAY_SETPOINT     = 3'd5,
        REG_NIGHT_SETPOINT   = 3'd6,
        REG_BAND_MARGIN      = 3'd7
    } t_sbt_reg;

    // request codes, two bit signed
    localparam logic signed [1:0] REQ_NONE  = 2'sb00;
    localparam logic signed [1:0] REQ_LOWER = 2'sb01;
    localparam logic signed [1:0] REQ_RAISE = 2'sb11;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               daytime;
        logic               dose_busy;
        logic               wait_busy;
    } t_sbt_in;

    typedef struct packed {
        logic signed [1:0] request;
        logic              active_now;
        logic [7:0]        consecutive_seen;
    } t_sbt_out;

    typedef struct packed {
        logic               control_enabled;
        logic               doser_mode;
        logic               raise_enable;
        logic               lower_enable;
        logic               day_night_enable;
        logic signed [31:0] day_setpoint;
        logic signed [31:0] night_setpoint;
        logic [30:0]        band_margin;
    } t_sbt_cfg;

endpackage
`default_nettype wire

// ----- rtl/sbt_decide.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// sbt_decide
// Combinational decision logic: band compare against the selected target,
// streak counter and active flag update, result formation.
// ---------------------------------------------------------------------------
module sbt_decide #(
    parameter int CHECKS_NEEDED = sbt_pkg::CHECKS_NEEDED_DEF,
    parameter int CNT_W         = $clog2(CHECKS_NEEDED + 1)
) (
    input  var sbt_pkg::t_sbt_cfg i_cfg,
    input  var sbt_pkg::t_sbt_in  i_item,
    input  wire [CNT_W-1:0]       i_streak,
    input  wire                   i_active,
    output logic [CNT_W-1:0]      o_streak,
    output logic                  o_active,
    output sbt_pkg::t_sbt_out     o_result
);
    import sbt_pkg::*;

    logic signed [31:0] target;
    logic signed [33:0] sample_x;
    logic signed [33:0] target_x;
    logic signed [33:0] margin_x;
    logic signed [33:0] band_lo;
    logic signed [33:0] band_hi;
    logic               under;
    logic               over;
    logic               gated;

    always_comb begin
        target   = (!i_item.daytime && i_cfg.day_night_enable) ? i_cfg.night_setpoint
                                                               : i_cfg.day_setpoint;
        sample_x = {{2{i_item.sample[31]}}, i_item.sample};
        target_x = {{2{target[31]}}, target};
        margin_x = {3'b000, i_cfg.band_margin};
        band_lo  = target_x - margin_x;
        band_hi  = target_x + margin_x;
        under    = i_cfg.raise_enable && (sample_x < band_lo);
        over     = i_cfg.lower_enable && (sample_x > band_hi);
        gated    = i_active && i_cfg.doser_mode && (i_item.dose_busy || i_item.wait_busy);
    end

    always_comb begin
        o_streak         = i_streak;
        o_active         = i_active;
        o_result.request = REQ_NONE;
        priority if (!i_cfg.control_enabled) begin
            o_streak = '0;
            o_active = 1'b0;
        end else if (gated) begin
            // timer running: hold everything
        end else if (under || over) begin
            if (i_streak >= CNT_W'(CHECKS_NEEDED)) begin
                o_streak         = '0;
                o_active         = 1'b1;
                o_result.request = under ? REQ_RAISE : REQ_LOWER;
            end else begin
                o_streak = i_streak + CNT_W'(1);
                if (!i_cfg.doser_mode) begin
                    o_active = 1'b0;
                end
            end
        end else begin
            // in band: a broken streak ends the doser hold
            if (i_streak != '0 && i_cfg.doser_mode) begin
                o_active = 1'b0;
            end
            o_streak = '0;
            if (!i_cfg.doser_mode) begin
                o_active = 1'b0;
            end
        end
        o_result.active_now       = o_active;
        o_result.consecutive_seen = 8'(o_streak);
    end

endmodule
`default_nettype wire

// ----- rtl/setpoint_band_trigger_unit.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// setpoint_band_trigger_unit
// Compares Q16.16 samples against a day/night target band and raises a
// raise or lower request after a streak of out-of-band samples.
// ---------------------------------------------------------------------------
// One sample is accepted per clock cycle, back to back, unless both registers
// hold data and the result side stalls. Each transaction passes an input
// register and a result register. The decision, counter and flag update all
// happen combinationally between those registers. A full result register
// does not stall input until the input register is also occupied.
// Configuration registers sit on the APB port at byte address 4*index; the
// user must write them only while no transaction is in flight, and the block
// does not enforce this. Writing 0 to control_enabled clears the streak
// counter and active flag.
// ---------------------------------------------------------------------------
module setpoint_band_trigger_unit #(
    parameter int CHECKS_NEEDED = sbt_pkg::CHECKS_NEEDED_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // sample channel
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  var sbt_pkg::t_sbt_in               i_in_data,
    // result channel
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output sbt_pkg::t_sbt_out                  o_out_data,
    // configuration port
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire [sbt_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire [sbt_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [sbt_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import sbt_pkg::*;

    localparam int CNT_W = $clog2(CHECKS_NEEDED + 1);

    t_sbt_cfg    r_cfg;
    t_sbt_in     r_in;
    logic        r_in_valid;
    t_sbt_out    r_out;
    logic        r_out_valid;
    logic [CNT_W-1:0] r_streak;
    logic        r_active;

    logic [CNT_W-1:0] n_streak;
    logic        n_active;
    t_sbt_out    n_out;
    logic        advance;
    logic        in_take;
    logic        cfg_wr;
    t_sbt_reg    reg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = t_sbt_reg'(paddr[4:2]);

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign in_take    = !r_in_valid || advance;
    assign o_in_stall = !in_take;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            REG_CONTROL_ENABLED:  prdata = {31'd0, r_cfg.control_enabled};
            REG_DOSER_MODE:       prdata = {31'd0, r_cfg.doser_mode};
            REG_RAISE_ENABLE:     prdata = {31'd0, r_cfg.raise_enable};
            REG_LOWER_ENABLE:     prdata = {31'd0, r_cfg.lower_enable};
            REG_DAY_NIGHT_ENABLE: prdata = {31'd0, r_cfg.day_night_enable};
            REG_DAY_SETPOINT:     prdata = r_cfg.day_setpoint;
            REG_NIGHT_SETPOINT:   prdata = r_cfg.night_setpoint;
            REG_BAND_MARGIN:      prdata = {1'b0, r_cfg.band_margin};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_CONTROL_ENABLED:  r_cfg.control_enabled  <= pwdata[0];
                REG_DOSER_MODE:       r_cfg.doser_mode       <= pwdata[0];
                REG_RAISE_ENABLE:     r_cfg.raise_enable     <= pwdata[0];
                REG_LOWER_ENABLE:     r_cfg.lower_enable     <= pwdata[0];
                REG_DAY_NIGHT_ENABLE: r_cfg.day_night_enable <= pwdata[0];
                REG_DAY_SETPOINT:     r_cfg.day_setpoint     <= pwdata;
                REG_NIGHT_SETPOINT:   r_cfg.night_setpoint   <= pwdata;
                REG_BAND_MARGIN:      r_cfg.band_margin      <= pwdata[30:0];
                default:              r_cfg <= r_cfg;
            endcase
        end
    end

    sbt_decide #(
        .CHECKS_NEEDED (CHECKS_NEEDED),
        .CNT_W         (CNT_W)
    ) u_decide (
        .i_cfg    (r_cfg),
        .i_item   (r_in),
        .i_streak (r_streak),
        .i_active (r_active),
        .o_streak (n_streak),
        .o_active (n_active),
        .o_result (n_out)
    );

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_streak    <= '0;
            r_active    <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            // disabling control clears the decision state
            if (cfg_wr && reg_sel == REG_CONTROL_ENABLED && !pwdata[0]) begin
                r_streak <= '0;
                r_active <= 1'b0;
            end else if (advance) begin
                r_streak <= n_streak;
                r_active <= n_active;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire

// ----- dv/sbt_checker.sv -----
// ---------------------------------------------------------------------------
// sbt_checker
// Watches the sample, result and configuration ports of the setpoint band
// trigger, predicts the result of every accepted sample and compares it
// field by field with the result transactions in order.
// ---------------------------------------------------------------------------
module sbt_checker
    import sbt_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    input  wire                   i_in_stall,
    input  t_sbt_in               i_in_data,
    input  wire                   i_out_valid,
    input  wire                   i_out_stall,
    input  t_sbt_out              i_out_data,
    input  wire                   i_psel,
    input  wire                   i_penable,
    input  wire                   i_pwrite,
    input  wire                   i_pready,
    input  wire [APB_ADDR_W-1:0]  i_paddr,
    input  wire [APB_DATA_W-1:0]  i_pwdata,
    output int                    o_mismatches,
    output int                    o_pending
);

    localparam int STREAK_LIMIT = CHECKS_NEEDED_DEF;

    t_sbt_cfg   band_cfg;
    logic [7:0] streak;
    logic       held_active;
    int         errors = 0;
    t_sbt_out   expected_results[$];

    function automatic t_sbt_out band_decision(input t_sbt_in s);
        t_sbt_out r;
        longint   target;
        longint   margin;
        longint   value;
        logic     under;
        logic     over;
        r = '0;
        r.request = REQ_NONE;
        if (!band_cfg.control_enabled) begin
            streak = '0;
            held_active = 1'b0;
            return r;
        end
        if (held_active && band_cfg.doser_mode && (s.dose_busy || s.wait_busy)) begin
            r.active_now = held_active;
            r.consecutive_seen = streak;
            return r;
        end
        if (!s.daytime && band_cfg.day_night_enable)
            target = longint'($signed(band_cfg.night_setpoint));
        else
            target = longint'($signed(band_cfg.day_setpoint));
        margin = longint'(band_cfg.band_margin);
        value = longint'($signed(s.sample));
        under = band_cfg.raise_enable && (value < target - margin);
        over = band_cfg.lower_enable && (value > target + margin);
        if (under || over) begin
            if (streak >= STREAK_LIMIT) begin
                // streak complete: fire and restart the count
                streak = '0;
                held_active = 1'b1;
                r.request = under ? REQ_RAISE : REQ_LOWER;
                r.active_now = 1'b1;
                return r;
            end
            streak = streak + 8'd1;
        end else if (streak != 0) begin
            if (band_cfg.doser_mode)
                held_active = 1'b0;
            streak = '0;
        end
        if (!band_cfg.doser_mode)
            held_active = 1'b0;
        r.active_now = held_active;
        r.consecutive_seen = streak;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_sbt_out want;
        if (!i_rst_n) begin
            band_cfg = '0;
            streak = '0;
            held_active = 1'b0;
            expected_results.delete();
            o_pending <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_sbt_reg'(i_paddr[APB_ADDR_W-1:2]))
                    REG_CONTROL_ENABLED: begin
                        band_cfg.control_enabled = i_pwdata[0];
                        if (!i_pwdata[0]) begin
                            streak = '0;
                            held_active = 1'b0;
                        end
                    end
                    REG_DOSER_MODE:       band_cfg.doser_mode = i_pwdata[0];
                    REG_RAISE_ENABLE:     band_cfg.raise_enable = i_pwdata[0];
                    REG_LOWER_ENABLE:     band_cfg.lower_enable = i_pwdata[0];
                    REG_DAY_NIGHT_ENABLE: band_cfg.day_night_enable = i_pwdata[0];
                    REG_DAY_SETPOINT:     band_cfg.day_setpoint = i_pwdata;
                    REG_NIGHT_SETPOINT:   band_cfg.night_setpoint = i_pwdata;
                    REG_BAND_MARGIN:      band_cfg.band_margin = i_pwdata[30:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result transaction: request %0d active %0b count %0d",
                                 $signed(i_out_data.request), i_out_data.active_now,
                                 i_out_data.consecutive_seen);
                end else begin
                    want = expected_results.pop_front();
                    if (want.request !== i_out_data.request
                            || want.active_now !== i_out_data.active_now
                            || want.consecutive_seen !== i_out_data.consecutive_seen) begin
                        errors++;
                        if (errors <= 10)
                            $display("result mismatch: request %0d/%0d active %0b/%0b count %0d/%0d (exp/act)",
                                     $signed(want.request), $signed(i_out_data.request),
                                     want.active_now, i_out_data.active_now,
                                     want.consecutive_seen, i_out_data.consecutive_seen);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(band_decision(i_in_data));
            o_pending <= expected_results.size();
        end
        o_mismatches <= errors;
    end

endmodule

// ----- dv/tb_setpoint_band_trigger_unit.sv -----
// ---------------------------------------------------------------------------
// tb_setpoint_band_trigger_unit
// Drives the setpoint band trigger with directed band-edge, streak and
// doser-gate samples, then random streaks around randomly programmed
// targets, with bursty input and a stalling result side.
// ---------------------------------------------------------------------------
module tb_setpoint_band_trigger_unit;
    import sbt_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_sbt_in               i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_sbt_out              o_out_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    mismatch_count;
    int                    results_pending;

    // stimulus-side copy of the programmed band, used to aim samples
    logic [31:0] day_sp = '0;
    logic [31:0] night_sp = '0;
    logic [30:0] band_width = '0;
    logic        night_en = 1'b0;
    int          burst_left = 0;
    int          stall_mode = 0;
    int          stall_tick = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    setpoint_band_trigger_unit dut (.*);

    sbt_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_mismatches (mismatch_count),
        .o_pending    (results_pending)
    );

    // result side stall pattern, switching to a random style whenever stall_tick wraps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_tick <= 0;
        end else begin
            if (stall_tick == 0)
                stall_mode <= $urandom_range(0, 3);
            stall_tick <= (stall_tick + 1) % 40;
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 1) == 0);
                default: i_out_stall <= ((stall_tick % 9) < 5);
            endcase
        end
    end

    task automatic cfg_write(input t_sbt_reg r, input logic [31:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic program_band(input logic en, input logic doser, input logic raise,
                                input logic lower, input logic dn, input logic [31:0] d,
                                input logic [31:0] n, input logic [30:0] m);
        cfg_write(REG_CONTROL_ENABLED, {31'b0, en});
        cfg_write(REG_DOSER_MODE, {31'b0, doser});
        cfg_write(REG_RAISE_ENABLE, {31'b0, raise});
        cfg_write(REG_LOWER_ENABLE, {31'b0, lower});
        cfg_write(REG_DAY_NIGHT_ENABLE, {31'b0, dn});
        cfg_write(REG_DAY_SETPOINT, d);
        cfg_write(REG_NIGHT_SETPOINT, n);
        cfg_write(REG_BAND_MARGIN, {1'b0, m});
        day_sp = d;
        night_sp = n;
        band_width = m;
        night_en = dn;
    endtask

    // stop sending and wait until every result transaction is back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic offer_sample(input logic [31:0] s, input logic day, input logic dose,
                                input logic wt);
        t_sbt_in it;
        it.sample = s;
        it.daytime = day;
        it.dose_busy = dose;
        it.wait_busy = wt;
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] pick_setpoint();
        case ($urandom_range(0, 9))
            7: return 32'h7FFF_FFFF;
            8: return 32'h8000_0000;
            9: return $urandom;
            default: return 32'($urandom_range(0, 32'h00C8_0000)) - 32'h0064_0000;
        endcase
    endfunction

    task automatic program_random_band(input int ph);
        logic [31:0] d;
        logic [30:0] m;
        logic        en;
        en = (ph == 2) ? 1'b0 : ($urandom_range(0, 7) != 0);
        d = pick_setpoint();
        m = ($urandom_range(0, 4) != 0) ? 31'($urandom_range(0, 32'h0002_0000))
                                         : 31'($urandom);
        // band reaching past the top (phase 0) or the bottom (phase 1) of the sample range
        if (ph == 0) begin
            d = 32'h7FFF_FFFF;
            m = '1;
        end
        if (ph == 1) begin
            d = 32'h8000_0000;
            m = '1;
        end
        program_band(en, 1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0,
                     $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)), d,
                     pick_setpoint(), m);
    endtask

    // streaks of under, over or in-band samples, with some pure noise
    task automatic random_runs(input int count);
        int          sent;
        int          len;
        int          kind;
        logic        day;
        longint      target;
        longint      s;
        logic [31:0] word;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(0, 19);
            len = $urandom_range(1, 8);
            day = 1'($urandom_range(0, 1));
            target = (!day && night_en) ? longint'($signed(night_sp))
                                        : longint'($signed(day_sp));
            for (int k = 0; k < len && sent < count; k++) begin
                if (kind < 7)
                    s = target - longint'(band_width) - $urandom_range(1, 32'h0003_0000);
                else if (kind < 14)
                    s = target + longint'(band_width) + $urandom_range(1, 32'h0003_0000);
                else if (kind < 18)
                    s = target - longint'(band_width)
                        + (longint'($urandom) % (2 * longint'(band_width) + 1));
                else
                    s = longint'($signed($urandom));
                if (s > 64'sd2147483647)
                    s = 64'sd2147483647;
                if (s < -64'sd2147483648)
                    s = -64'sd2147483648;
                word = s[31:0];
                offer_sample(word, day, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // disabled after reset: nothing fires, whatever comes in
        offer_sample(32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0);
        offer_sample(32'h8000_0000, 1'b0, 1'b1, 1'b1);
        wait_drained();

        // day 1.0, night -5.0, margin 0.5
        program_band(1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 32'h0001_0000, 32'hFFFB_0000,
                     31'h0000_8000);
        repeat (6) offer_sample(32'h8000_0000, 1'b1, 1'b0, 1'b0);
        repeat (6) offer_sample(32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0);
        offer_sample(32'h0001_8000, 1'b1, 1'b0, 1'b0);  // upper band edge, in band
        offer_sample(32'h0000_7FFF, 1'b1, 1'b0, 1'b0);  // just under lower edge
        offer_sample(32'h0000_0000, 1'b0, 1'b0, 1'b0);  // over the night target
        offer_sample(32'hFFFB_0000, 1'b0, 1'b0, 1'b0);  // on the night target
        wait_drained();

        // doser: active holds, timers gate, in-band after a count releases
        program_band(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 32'h0001_0000, 32'hFFFB_0000,
                     31'h0000_8000);
        repeat (6) offer_sample(32'h0002_0000, 1'b1, 1'b0, 1'b0);
        offer_sample(32'h0002_0000, 1'b1, 1'b1, 1'b0);
        offer_sample(32'h0002_0000, 1'b1, 1'b0, 1'b1);
        offer_sample(32'h0001_0000, 1'b1, 1'b0, 1'b0);
        offer_sample(32'h0002_0000, 1'b1, 1'b0, 1'b0);
        offer_sample(32'h0001_0000, 1'b1, 1'b0, 1'b0);
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            program_random_band(ph);
            random_runs(50);
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #3000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
